@@ hdl/rau_pkg.sv @@
// rau_pkg: payload structs, command and status codes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_CMP  = 3'd4,
        CMD_NORM = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] a_num;
        logic signed [63:0] a_den;
        logic signed [63:0] b_num;
        logic signed [63:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } out_item_t;

endpackage

@@ hdl/rational_arith_unit.sv @@
// rational_arith_unit: exact add/sub/mul/div/compare/normalise of two signed fractions.
// Depends on rau_pkg. Single module with a shared 128-bit subtract/shift datapath.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries command and two fractions.
//   Output channel out_valid/out_stall/out_data returns one result per transfer.
//   in_stall is high whenever an item is being worked on or a result waits.
//   Products are formed by a shift-add multiplier, one bit a cycle (up to
//   three products). The result is reduced by a binary GCD that removes one
//   bit or does one subtract a cycle, then divided by the GCD in two restoring
//   divisions. Latency is therefore data dependent; compare skips the GCD and
//   divisions, and errors and a zero normalise operand go straight to the
//   output. One item at a time.
//   Reset empties the unit; no item is lost once accepted. While the receiver
//   stalls the result is held unchanged and no new item is taken.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rau_pkg::out_item_t out_data
);
    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * W;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PREP  = 12'b000000000010,
        S_MUL   = 12'b000000000100,
        S_MNEXT = 12'b000000001000,
        S_COMB  = 12'b000000010000,
        S_GSH   = 12'b000000100000,
        S_GODD  = 12'b000001000000,
        S_GLOOP = 12'b000010000000,
        S_GFIX  = 12'b000100000000,
        S_DIV   = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]   cmd_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         as_reg, bs_reg;
    logic [DW-1:0] p0_reg, p1_reg, p2_reg;
    logic [1:0]   mi_reg;
    logic [DW-1:0] mac_reg, mpl_reg;
    logic [W-1:0] mer_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] nm_reg, dn_reg;
    logic          nneg_reg;
    logic [DW-1:0] ga_reg, gb_reg;
    logic [CW-1:0] sh_reg;
    logic          dsel_reg;
    logic [DW-1:0] q_reg, r_reg, src_reg, qn_reg;
    rau_pkg::out_item_t res_reg;

    function automatic logic [W-1:0] mag_of(input logic [63:0] v);
        logic [W-1:0] t;
        t = v[W-1:0];
        return t[W-1] ? (~t + 1'b1) : t;
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    // product index being loaded: first one in S_PREP, the next one in S_MNEXT
    logic [1:0] mi_sel;
    always_comb
    begin
        if (state_reg == S_PREP)
            mi_sel = 2'd0;
        else
            mi_sel = mi_reg + 2'd1;
    end

    // operand fetch for products: 0 an*bd (an*bn for MUL), 1 bn*ad (ad*bn for DIV, ad*bd for MUL), 2 ad*bd
    logic [W-1:0] m_x, m_y;
    always_comb
    begin
        m_x = an_reg;
        m_y = bd_reg;
        case (cmd_reg)
            rau_pkg::CMD_MUL:
            begin
                if (mi_sel == 2'd0)
                begin
                    m_x = an_reg; m_y = bn_reg;
                end
                else
                begin
                    m_x = ad_reg; m_y = bd_reg;
                end
            end
            rau_pkg::CMD_DIV:
            begin
                if (mi_sel == 2'd0)
                begin
                    m_x = an_reg; m_y = bd_reg;
                end
                else
                begin
                    m_x = ad_reg; m_y = bn_reg;
                end
            end
            default:
            begin
                if (mi_sel == 2'd0)
                begin
                    m_x = an_reg; m_y = bd_reg;
                end
                else if (mi_sel == 2'd1)
                begin
                    m_x = bn_reg; m_y = ad_reg;
                end
                else
                begin
                    m_x = ad_reg; m_y = bd_reg;
                end
            end
        endcase
    end

    logic [1:0] nprod;
    always_comb
    begin
        case (cmd_reg)
            rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: nprod = 2'd2;
            rau_pkg::CMD_CMP:                   nprod = 2'd2;
            default:                            nprod = 2'd3;
        endcase
    end

    // shared subtractor
    logic [DW-1:0] sub_a, sub_b;
    logic [DW:0]   sub_r;
    assign sub_r = {1'b0, sub_a} - {1'b0, sub_b};

    logic [DW-1:0] r_sh;
    assign r_sh = {r_reg[DW-2:0], src_reg[DW-1]};

    always_comb
    begin
        sub_a = r_sh;
        sub_b = ga_reg;
        if (state_reg == S_GLOOP)
        begin
            sub_a = gb_reg; sub_b = ga_reg;
        end
        else if (state_reg == S_COMB)
        begin
            sub_a = p0_reg; sub_b = p1_reg;
        end
    end

    logic         is_neg_sub;
    logic [DW-1:0] lim;
    logic          ovf;
    always_comb
    begin
        lim = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
        ovf = (r_reg > lim) || (qn_reg > (lim + {{(DW-1){1'b0}}, nneg_reg}));
        is_neg_sub = sub_r[DW];
    end

    logic [DW-1:0] q_nxt;
    assign q_nxt = {q_reg[DW-2:0], ~is_neg_sub};

    logic a_zden, b_zden, a_s_in, b_s_in;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic [1:0]   st_in;
    always_comb
    begin
        an_m = mag_of(in_data.a_num);
        ad_m = mag_of(in_data.a_den);
        bn_m = mag_of(in_data.b_num);
        bd_m = mag_of(in_data.b_den);
        a_zden = (ad_m == '0);
        b_zden = (bd_m == '0);
        a_s_in = (in_data.a_num[W-1] ^ in_data.a_den[W-1]) && (an_m != '0);
        b_s_in = (in_data.b_num[W-1] ^ in_data.b_den[W-1]) && (bn_m != '0);
        if (a_zden || (in_data.cmd <= rau_pkg::CMD_CMP && b_zden))
            st_in = rau_pkg::ST_ZDEN;
        else if (in_data.cmd == rau_pkg::CMD_DIV && bn_m == '0)
            st_in = rau_pkg::ST_DIV0;
        else
            st_in = rau_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PREP;
            S_PREP:
            begin
                if (res_reg.status != rau_pkg::ST_OK)
                    state_next = S_OUT;
                else if (cmd_reg >= rau_pkg::CMD_NORM)
                    state_next = (an_reg == '0) ? S_OUT : S_GSH;
                else
                    state_next = S_MUL;
            end
            S_MUL:   if (cnt_reg == CW'(W - 1)) state_next = S_MNEXT;
            S_MNEXT: state_next = (mi_reg == nprod - 2'd1) ? S_COMB : S_MUL;
            S_COMB:  state_next = (cmd_reg == rau_pkg::CMD_CMP) ? S_OUT : S_GSH;
            S_GSH:
            begin
                if (nm_reg == '0)
                    state_next = S_OUT;
                else if (ga_reg[0] || gb_reg[0])
                    state_next = S_GODD;
            end
            S_GODD:  if (ga_reg[0]) state_next = S_GLOOP;
            S_GLOOP: if (gb_reg == '0) state_next = S_GFIX;
            S_GFIX:  if (sh_reg == '0) state_next = S_DIV;
            S_DIV:   if (cnt_reg == CW'(DW - 1) && dsel_reg) state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg <= in_data.cmd;
                    an_reg  <= an_m;
                    ad_reg  <= ad_m;
                    bn_reg  <= bn_m;
                    bd_reg  <= bd_m;
                    as_reg  <= a_s_in;
                    bs_reg  <= (in_data.cmd == rau_pkg::CMD_SUB ||
                                in_data.cmd == rau_pkg::CMD_CMP) ?
                               (~b_s_in && bn_m != '0) : b_s_in;
                    res_reg <= '{res_num: '0, res_den: 63'd1, order: rau_pkg::ORD_LT,
                                 status: st_in};
                end
            end
            S_PREP:
            begin
                mi_reg  <= 2'd0;
                cnt_reg <= '0;
                mac_reg <= '0;
                mpl_reg <= DW'(m_x);
                mer_reg <= m_y;
                if (cmd_reg >= rau_pkg::CMD_NORM)
                begin
                    nm_reg   <= DW'(an_reg);
                    dn_reg   <= DW'(ad_reg);
                    nneg_reg <= as_reg;
                    ga_reg   <= DW'(an_reg);
                    gb_reg   <= DW'(ad_reg);
                    sh_reg   <= '0;
                end
            end
            S_MUL:
            begin
                if (mer_reg[0])
                    mac_reg <= mac_reg + mpl_reg;
                mpl_reg <= {mpl_reg[DW-2:0], 1'b0};
                mer_reg <= {1'b0, mer_reg[W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_MNEXT:
            begin
                case (mi_reg)
                    2'd0:    p0_reg <= mac_reg;
                    2'd1:    p1_reg <= mac_reg;
                    default: p2_reg <= mac_reg;
                endcase
                mi_reg  <= mi_reg + 1'b1;
                cnt_reg <= '0;
                mac_reg <= '0;
                mpl_reg <= DW'(m_x);
                mer_reg <= m_y;
            end
            S_COMB:
            begin
                sh_reg <= '0;
                case (cmd_reg)
                    rau_pkg::CMD_MUL:
                    begin
                        nm_reg <= p0_reg; nneg_reg <= as_reg ^ bs_reg;
                        dn_reg <= p1_reg; ga_reg <= p0_reg; gb_reg <= p1_reg;
                    end
                    rau_pkg::CMD_DIV:
                    begin
                        nm_reg <= p0_reg; nneg_reg <= as_reg ^ bs_reg;
                        dn_reg <= p1_reg; ga_reg <= p0_reg; gb_reg <= p1_reg;
                    end
                    default:
                    begin
                        // signed sum of x = as*p0 and y = bs*p1
                        logic [DW-1:0] s;
                        logic sn;
                        if (as_reg == bs_reg)
                        begin
                            s = p0_reg + p1_reg; sn = as_reg;
                        end
                        else if (!is_neg_sub)
                        begin
                            s = sub_r[DW-1:0]; sn = as_reg;
                        end
                        else
                        begin
                            s = p1_reg - p0_reg; sn = bs_reg;
                        end
                        if (s == '0) sn = 1'b0;
                        nm_reg <= s; nneg_reg <= sn;
                        dn_reg <= p2_reg; ga_reg <= s; gb_reg <= p2_reg;
                        if (cmd_reg == rau_pkg::CMD_CMP)
                            res_reg.order <= (s == '0) ? rau_pkg::ORD_EQ :
                                             (sn ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
                    end
                endcase
            end
            S_GSH:
            begin
                if (!(ga_reg[0] || gb_reg[0]))
                begin
                    ga_reg <= ga_reg >> 1;
                    gb_reg <= gb_reg >> 1;
                    sh_reg <= sh_reg + 1'b1;
                end
            end
            S_GODD:  if (!ga_reg[0]) ga_reg <= ga_reg >> 1;
            S_GLOOP:
            begin
                if (gb_reg != '0)
                begin
                    if (!gb_reg[0])
                        gb_reg <= gb_reg >> 1;
                    else if (is_neg_sub)
                    begin
                        ga_reg <= gb_reg;
                        gb_reg <= ga_reg - gb_reg;
                    end
                    else
                        gb_reg <= sub_r[DW-1:0];
                end
            end
            S_GFIX:
            begin
                if (sh_reg != '0)
                begin
                    ga_reg <= {ga_reg[DW-2:0], 1'b0};
                    sh_reg <= sh_reg - 1'b1;
                end
                else
                begin
                    src_reg  <= nm_reg;
                    r_reg    <= '0;
                    q_reg    <= '0;
                    cnt_reg  <= '0;
                    dsel_reg <= 1'b0;
                end
            end
            S_DIV:
            begin
                if (cnt_reg != CW'(DW - 1))
                begin
                    r_reg   <= is_neg_sub ? r_sh : sub_r[DW-1:0];
                    q_reg   <= q_nxt;
                    src_reg <= {src_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else if (!dsel_reg)
                begin
                    qn_reg   <= q_nxt;
                    src_reg  <= dn_reg;
                    r_reg    <= '0;
                    q_reg    <= '0;
                    cnt_reg  <= '0;
                    dsel_reg <= 1'b1;
                end
                else
                    r_reg <= q_nxt;
            end
            S_FIN:
            begin
                // r_reg holds reduced denominator, qn_reg reduced numerator magnitude
                if (ovf)
                    res_reg.status <= rau_pkg::ST_OVF;
                else
                    res_reg <= '{res_num: 64'(signed'(nneg_reg ? (~qn_reg[W-1:0] + 1'b1)
                                                               : qn_reg[W-1:0])),
                                 res_den: 63'(r_reg[W-1:0]),
                                 order: res_reg.order,
                                 status: res_reg.status};
            end
            default: ;
        endcase
    end

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
    endproperty
    assert property (p_stall_busy) else $error("input taken while result pending");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=> (out_valid && $stable(out_data));
    endproperty
    assert property (p_out_hold) else $error("stalled result changed");

    property p_den_pos;
        @(posedge clk) disable iff (!rst_n) out_valid |-> (out_data.res_den != '0);
    endproperty
    assert property (p_den_pos) else $error("zero denominator delivered");

    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && out_data.status != rau_pkg::ST_OK) |-> (out_data.res_num == '0);
    endproperty
    assert property (p_err_zero) else $error("error result carries numerator");

endmodule
